// ===== design/feature_lock_table_assert.svh =====
`ifndef FEATURE_LOCK_TABLE_ASSERT_SVH
`define FEATURE_LOCK_TABLE_ASSERT_SVH

// next-cycle implication, checked outside reset
`define FLT_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("flt check failed: next-cycle rule");

// same-cycle implication, checked outside reset
`define FLT_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("flt check failed: same-cycle rule");

`endif

// ===== design/flt_pkg.sv =====
package flt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int FEATURE_BITS  = 32;

    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int CMD_W     = 2;
    localparam int OWNER_W   = 8;
    localparam int COMP_W    = 16;
    localparam int FMASK_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int MASK_W    = (FEATURE_BITS < FMASK_W) ? FEATURE_BITS : FMASK_W;
    localparam int ENTRY_W   = OWNER_W + COMP_W + MASK_W;

    localparam logic [CMD_W-1:0] CMD_LOCK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNLOCK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BAD     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_CMD   = 3'd4;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [COMP_W-1:0]  component;
        logic [MASK_W-1:0]  mask;
    } flt_entry_t;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             commit;
    } flt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } flt_stat_t;

endpackage

// ===== design/flt_req_if.sv =====
interface flt_req_if import flt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [OWNER_W-1:0]   owner;
    logic [COMP_W-1:0]    component;
    logic [FMASK_W-1:0]   feature_mask;

    modport source (output valid, output cmd, output owner, output component,
                    output feature_mask, input ready);
    modport sink   (input valid, input cmd, input owner, input component,
                    input feature_mask, output ready);
endinterface

// ===== design/flt_rsp_if.sv =====
interface flt_rsp_if import flt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FMASK_W-1:0]  held_mask;

    modport source (output valid, output status, output held_mask, input ready);
    modport sink   (input valid, input status, input held_mask, output ready);
endinterface

// ===== design/flt_ram.sv =====
module flt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/flt_ctrl.sv =====
module flt_ctrl import flt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output flt_cmd_t  ctl,
    input  flt_stat_t st
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    localparam logic [IDX_W:0] CNT_LAST = (IDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [IDX_W:0] CNT_ONE  = (IDX_W + 1)'(1);

    logic [1:0]     state_reg, state_next;
    logic [IDX_W:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        req_ready   = 1'b0;
        ctl.load    = 1'b0;
        ctl.rd_en   = 1'b0;
        ctl.rd_addr = cnt_reg[IDX_W-1:0];
        ctl.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // reads for every entry, then holds here without a read for the last compare
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                    cnt_next  = cnt_reg + CNT_ONE;
                end
            end
            S_UPDATE:
            begin
                if (!st.out_busy)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/flt_datapath.sv =====
module flt_datapath import flt_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  flt_cmd_t            ctl,
    output flt_stat_t           st,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [OWNER_W-1:0]  owner,
    input  logic [COMP_W-1:0]   component,
    input  logic [FMASK_W-1:0]  feature_mask,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] rsp_status,
    output logic [FMASK_W-1:0]  rsp_held_mask
);

    // request word
    logic [CMD_W-1:0]   cmd_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [COMP_W-1:0]  comp_reg;
    logic [MASK_W-1:0]  req_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    // scan results
    logic              cmp_en_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              busy_reg, busy_next;
    logic              mine_found_reg, mine_found_next;
    logic [IDX_W-1:0]  mine_idx_reg, mine_idx_next;
    logic [MASK_W-1:0] mine_mask_reg, mine_mask_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;

    // result word
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [MASK_W-1:0]   out_held_reg;

    flt_entry_t        rd_ent;
    flt_entry_t        wr_ent;
    logic [ENTRY_W-1:0] rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic              ent_valid;
    logic              comp_hit;
    logic              set_valid, clr_valid;
    logic [STATUS_W-1:0] res_status;
    logic [MASK_W-1:0]   res_held;
    logic [MASK_W-1:0]   new_mask;

    flt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_ent),
        .re    (ctl.rd_en),
        .raddr (ctl.rd_addr),
        .rdata (rd_data)
    );

    assign rd_ent    = flt_entry_t'(rd_data);
    assign ent_valid = valid_reg[cmp_idx_reg];
    assign comp_hit  = ent_valid && (rd_ent.component == comp_reg);

    // scan compare, one entry per cycle
    always_comb
    begin
        busy_next       = busy_reg;
        mine_found_next = mine_found_reg;
        mine_idx_next   = mine_idx_reg;
        mine_mask_next  = mine_mask_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        if (ctl.load)
        begin
            busy_next       = 1'b0;
            mine_found_next = 1'b0;
            free_found_next = 1'b0;
        end
        else if (cmp_en_reg)
        begin
            if (comp_hit && ((rd_ent.mask & req_reg) != '0))
            begin
                busy_next = 1'b1;
            end
            if (comp_hit && (rd_ent.owner == owner_reg) && !mine_found_reg)
            begin
                mine_found_next = 1'b1;
                mine_idx_next   = cmp_idx_reg;
                mine_mask_next  = rd_ent.mask;
            end
            if (!ent_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
        end
    end

    // decision at the end of the scan
    always_comb
    begin
        wr_en      = 1'b0;
        wr_idx     = mine_idx_reg;
        wr_ent     = '{owner: owner_reg, component: comp_reg, mask: req_reg};
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        res_status = ST_OK;
        res_held   = '0;
        new_mask   = mine_mask_reg | req_reg;
        unique case (cmd_reg)
            CMD_LOCK:
            begin
                if (busy_reg)
                begin
                    res_status = ST_BUSY;
                    res_held   = mine_found_reg ? mine_mask_reg : '0;
                end
                else if (mine_found_reg)
                begin
                    wr_en       = 1'b1;
                    wr_ent.mask = new_mask;
                    res_held    = new_mask;
                end
                else if (free_found_reg)
                begin
                    wr_en     = 1'b1;
                    wr_idx    = free_idx_reg;
                    set_valid = 1'b1;
                    res_held  = req_reg;
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            CMD_UNLOCK:
            begin
                new_mask = mine_mask_reg & ~req_reg;
                if (mine_found_reg)
                begin
                    wr_en       = 1'b1;
                    wr_ent.mask = new_mask;
                    res_held    = new_mask;
                    clr_valid   = (new_mask == '0);
                end
                else
                begin
                    res_status = ST_NOT_FOUND;
                end
            end
            CMD_RELEASE:
            begin
                res_status = ST_OK;
            end
            CMD_BAD:
            begin
                res_status = ST_BAD_CMD;
            end
            default:
            begin
                res_status = ST_BAD_CMD;
            end
        endcase
        wr_en = wr_en && ctl.commit;
    end

    always_comb
    begin
        valid_next = valid_reg;
        // release drops every entry of the owner while scanning
        if (cmp_en_reg && (cmd_reg == CMD_RELEASE) && ent_valid &&
            (rd_ent.owner == owner_reg))
        begin
            valid_next[cmp_idx_reg] = 1'b0;
        end
        if (ctl.commit && set_valid)
        begin
            valid_next[wr_idx] = 1'b1;
        end
        if (ctl.commit && clr_valid)
        begin
            valid_next[wr_idx] = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            cmp_en_reg     <= 1'b0;
            busy_reg       <= 1'b0;
            mine_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            cmp_en_reg     <= ctl.rd_en;
            busy_reg       <= busy_next;
            mine_found_reg <= mine_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= ctl.rd_addr;
        mine_idx_reg  <= mine_idx_next;
        mine_mask_reg <= mine_mask_next;
        free_idx_reg  <= free_idx_next;
        if (ctl.load)
        begin
            cmd_reg   <= cmd;
            owner_reg <= owner;
            comp_reg  <= component;
            req_reg   <= feature_mask[MASK_W-1:0];
        end
        if (ctl.commit)
        begin
            out_status_reg <= res_status;
            out_held_reg   <= res_held;
        end
    end

    assign st.out_busy   = out_valid_reg && !rsp_ready;
    assign rsp_valid     = out_valid_reg;
    assign rsp_status    = out_status_reg;
    assign rsp_held_mask = FMASK_W'(out_held_reg);

endmodule

// ===== design/feature_lock_table.sv =====
// feature lock table
// req channel: one word per command (try lock, unlock, release all of owner),
// carrying owner, component and feature mask. rsp channel: one word per
// command with status and the owner's held mask after the command.
// every command walks all TABLE_ENTRIES entries of the entry memory through
// its single read port, one entry per cycle, then applies its update in the
// update state once the output register is free, loading the response word;
// a new command is taken only after that, from the cycle after the response
// is loaded, so a command is never accepted while another is in progress.
// req.ready is high only while no command is being worked on.
// the response sits in an output register; a stalled receiver does not stop
// the next command from being taken and scanned, only its final update
// waits until the register is free.
// reset clears all entry valid bits at once, so the table is empty right
// after reset with no clearing pass.
`include "feature_lock_table_assert.svh"

module feature_lock_table import flt_pkg::*; (
    input logic          clk,
    input logic          rst_n,
    flt_req_if.sink      req,
    flt_rsp_if.source    rsp
);

    flt_cmd_t  ctl;
    flt_stat_t st;
    logic      ready;

    flt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .ctl       (ctl),
        .st        (st)
    );

    flt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .st            (st),
        .cmd           (req.cmd),
        .owner         (req.owner),
        .component     (req.component),
        .feature_mask  (req.feature_mask),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_status    (rsp.status),
        .rsp_held_mask (rsp.held_mask)
    );

    assign req.ready = ready;

    `FLT_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
    `FLT_ASSERT_NOW(a_commit_needs_room, ctl.commit, !(rsp.valid && !rsp.ready))
    `FLT_ASSERT_NOW(a_no_read_when_idle, req.ready, !ctl.rd_en && !ctl.commit)
    `FLT_ASSERT_NOW(a_status_range, rsp.valid, rsp.status <= ST_BAD_CMD)

endmodule

// ===== sim/feature_lock_table_test.sv =====
`timescale 1ns / 100ps

module feature_lock_table_test;
    import flt_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [FMASK_W-1:0]  held_mask;
    } lock_reply_t;

    // mirror of the lock table; predicts the reply word for every accepted command
    class lock_table_scoreboard;
        bit                 used[TABLE_ENTRIES];
        logic [OWNER_W-1:0] slot_owner[TABLE_ENTRIES];
        logic [COMP_W-1:0]  slot_comp[TABLE_ENTRIES];
        logic [MASK_W-1:0]  slot_bits[TABLE_ENTRIES];
        lock_reply_t        awaited[$];
        int                 failures;

        function int find_slot(logic [OWNER_W-1:0] owner, logic [COMP_W-1:0] comp);
            int hit;
            hit = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (hit < 0 && used[i] && slot_owner[i] == owner && slot_comp[i] == comp)
                    hit = i;
            end
            return hit;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [OWNER_W-1:0] owner,
                                   logic [COMP_W-1:0] comp, logic [FMASK_W-1:0] fmask);
            lock_reply_t       r;
            logic [MASK_W-1:0] want;
            int                mine;
            bit                busy;
            want = fmask[MASK_W-1:0];
            r.status = ST_OK;
            r.held_mask = '0;
            mine = find_slot(owner, comp);
            case (cmd)
                CMD_LOCK:
                begin
                    busy = 1'b0;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (used[i] && slot_comp[i] == comp && (slot_bits[i] & want) != '0)
                            busy = 1'b1;
                    end
                    if (busy)
                    begin
                        r.status = ST_BUSY;
                        if (mine >= 0)
                            r.held_mask = slot_bits[mine];
                    end
                    else
                    begin
                        // lowest free entry when the owner has none for this component
                        for (int i = 0; i < TABLE_ENTRIES && mine < 0; i++)
                        begin
                            if (!used[i])
                            begin
                                mine = i;
                                used[i] = 1'b1;
                                slot_owner[i] = owner;
                                slot_comp[i] = comp;
                                slot_bits[i] = '0;
                            end
                        end
                        if (mine < 0)
                            r.status = ST_FULL;
                        else
                        begin
                            slot_bits[mine] |= want;
                            r.held_mask = slot_bits[mine];
                        end
                    end
                end
                CMD_UNLOCK:
                begin
                    if (mine < 0)
                        r.status = ST_NOT_FOUND;
                    else
                    begin
                        slot_bits[mine] &= ~want;
                        r.held_mask = slot_bits[mine];
                        if (slot_bits[mine] == '0)
                            used[mine] = 1'b0;
                    end
                end
                CMD_RELEASE:
                begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (used[i] && slot_owner[i] == owner)
                            used[i] = 1'b0;
                    end
                end
                default:
                    r.status = ST_BAD_CMD;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_reply(logic [STATUS_W-1:0] status, logic [FMASK_W-1:0] held);
            lock_reply_t r;
            if (awaited.size() == 0)
            begin
                $display("%0t: reply word with nothing pending: status %0d held %h",
                         $time, status, held);
                failures++;
                return;
            end
            r = awaited.pop_front();
            if (status !== r.status)
            begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, r.status, status);
                failures++;
            end
            if (held !== r.held_mask)
            begin
                $display("%0t: held_mask mismatch: expected %h actual %h",
                         $time, r.held_mask, held);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;

    lock_table_scoreboard sb = new;

    flt_req_if req();
    flt_rsp_if rsp();

    feature_lock_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // valid stays high after acceptance so back-to-back words need no lowering
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [OWNER_W-1:0] owner,
                             logic [COMP_W-1:0] comp, logic [FMASK_W-1:0] fmask);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid        <= 1'b1;
        req.cmd          <= cmd;
        req.owner        <= owner;
        req.component    <= comp;
        req.feature_mask <= fmask;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(cmd, owner, comp, fmask);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [FMASK_W-1:0] pick_mask();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return 32'd1 << $urandom_range(0, 7);
        else if (roll < 50)
            return 32'd1 << $urandom_range(0, 31);
        else if (roll < 65)
            return $urandom & $urandom & $urandom;
        else if (roll < 75)
            return '0;
        else if (roll < 85)
            return '1;
        return $urandom;
    endfunction

    // fill phases open with locks on fresh components until the table overflows
    task automatic run_phase(bit fill, int count);
        logic [OWNER_W-1:0] pool_owner[4];
        logic [COMP_W-1:0]  pool_comp[4];
        bit                 touched[256];
        logic [OWNER_W-1:0] who;
        logic [COMP_W-1:0]  what;
        logic [CMD_W-1:0]   op;
        int                 roll;
        foreach (pool_owner[k])
            pool_owner[k] = OWNER_W'($urandom);
        foreach (pool_comp[k])
            pool_comp[k] = COMP_W'($urandom);
        for (int done = 0; done < count; done++)
        begin
            roll = $urandom_range(0, 99);
            who = pool_owner[$urandom_range(0, fill ? 3 : 2)];
            what = pool_comp[$urandom_range(0, fill ? 3 : 2)];
            if ($urandom_range(0, 19) == 0)
                who = OWNER_W'($urandom);
            if (fill && done < TABLE_ENTRIES + 6)
            begin
                op = CMD_LOCK;
                what = COMP_W'($urandom);
            end
            else if (roll < 55)
                op = CMD_LOCK;
            else if (roll < 85)
                op = CMD_UNLOCK;
            else if (roll < 94)
                op = CMD_RELEASE;
            else
                op = CMD_BAD;
            touched[who] = 1'b1;
            send_word(op, who, what, pick_mask());
        end
        // leave the table empty for the next phase
        for (int k = 0; k < 256; k++)
        begin
            if (touched[k])
                send_word(CMD_RELEASE, k[OWNER_W-1:0], COMP_W'($urandom), $urandom);
        end
    endtask

    // reply side: random stall before each word
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
            sb.check_reply(rsp.status, rsp.held_mask);
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        idle_on          = 1'b1;
        req.valid        = 1'b0;
        req.cmd          = CMD_LOCK;
        req.owner        = '0;
        req.component    = '0;
        req.feature_mask = '0;
        rsp.ready        = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(CMD_BAD, 8'hff, 16'hffff, 32'hffff_ffff);
        send_word(CMD_UNLOCK, 8'h00, 16'h0000, 32'h0000_0001);
        send_word(CMD_RELEASE, 8'h07, 16'h1234, 32'h0000_0000);
        // zero-mask lock takes an entry and never collides
        send_word(CMD_LOCK, 8'h00, 16'h0000, 32'h0000_0000);
        send_word(CMD_LOCK, 8'h01, 16'h0000, 32'hffff_ffff);
        send_word(CMD_LOCK, 8'h00, 16'h0000, 32'h0000_0001);
        send_word(CMD_LOCK, 8'h00, 16'h0000, 32'h0000_0000);
        send_word(CMD_UNLOCK, 8'h00, 16'h0000, 32'h0000_0000);
        send_word(CMD_UNLOCK, 8'h01, 16'h0000, 32'h0000_ffff);
        send_word(CMD_LOCK, 8'hff, 16'hffff, 32'h8000_0000);
        send_word(CMD_LOCK, 8'hff, 16'hffff, 32'h0000_0001);
        send_word(CMD_LOCK, 8'h01, 16'hffff, 32'h0000_0001);
        send_word(CMD_LOCK, 8'h01, 16'hffff, 32'h0000_0002);
        send_word(CMD_LOCK, 8'hff, 16'hffff, 32'h0000_0002);
        send_word(CMD_UNLOCK, 8'hff, 16'hffff, 32'hffff_ffff);
        send_word(CMD_RELEASE, 8'h01, 16'h0000, 32'hffff_ffff);
        send_word(CMD_UNLOCK, 8'h01, 16'h0000, 32'hffff_ffff);
        send_word(CMD_BAD, 8'h00, 16'h0000, 32'h0000_0000);
        send_word(CMD_LOCK, 8'haa, 16'h5555, 32'h5555_5555);
        send_word(CMD_LOCK, 8'h55, 16'haaaa, 32'haaaa_aaaa);
        send_word(CMD_RELEASE, 8'haa, 16'h0000, 32'h0000_0000);
        send_word(CMD_RELEASE, 8'h55, 16'h0000, 32'h0000_0000);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            idle_on = (p % 3 != 2);
            run_phase(p % 2 == 0, 120);
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (sb.failures == 0 && sb.awaited.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/flt_pkg.sv
design/flt_req_if.sv
design/flt_rsp_if.sv
design/flt_ram.sv
design/flt_ctrl.sv
design/flt_datapath.sv
design/feature_lock_table.sv
sim/feature_lock_table_test.sv
